// ===== hw/rtl/aabb_xf_pkg.sv =====
// Shared constants and types for the transformed bounding-box block.
package aabb_xf_pkg;

  localparam int FIELD_W         = 32;
  localparam int FRAC_W          = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int AXES            = 3;
  localparam int ROW_TERMS       = 4;

  localparam logic signed [FIELD_W-1:0] Q_ONE  = 32'sd65536;
  localparam logic signed [FIELD_W-1:0] Q_HALF = 32'sd32768;

  // op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BOX  = 1'b1;

  // row code that names no matrix row
  localparam logic [1:0] ROW_NONE = 2'd3;

  // coefficient positions within a row
  localparam int TERM_A = 0;
  localparam int TERM_B = 1;
  localparam int TERM_C = 2;
  localparam int TERM_T = 3;

  typedef struct packed {
    logic signed [FIELD_W-1:0] lo;
    logic signed [FIELD_W-1:0] hi;
    logic                      ovf;
  } axis_res_t;

endpackage

// ===== hw/rtl/aabb_xf_if.sv =====
// Input and result channel interfaces for the transformed bounding-box block.
interface aabb_xf_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic [1:0]        row;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;
  logic signed [31:0] coef_t;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] min_z;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;
  logic signed [31:0] max_z;

  modport source (
    output valid, op, row, coef_a, coef_b, coef_c, coef_t,
    output min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );
  modport sink (
    input  valid, op, row, coef_a, coef_b, coef_c, coef_t,
    input  min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );
endinterface

interface aabb_xf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_min_x;
  logic signed [31:0] out_min_y;
  logic signed [31:0] out_min_z;
  logic signed [31:0] out_max_x;
  logic signed [31:0] out_max_y;
  logic signed [31:0] out_max_z;
  logic               overflow;

  modport source (
    output valid, out_min_x, out_min_y, out_min_z,
    output out_max_x, out_max_y, out_max_z, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_min_x, out_min_y, out_min_z,
    input  out_max_x, out_max_y, out_max_z, overflow,
    output ready
  );
endinterface

// ===== hw/rtl/aabb_xf_axis.sv =====
// One output axis: products, per-term min/max, rounded sums, saturation.
module aabb_xf_axis
  import aabb_xf_pkg::*;
#(
  parameter int  COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W,
  localparam int MW = (CW < FRAC_W + 2) ? FRAC_W + 2 : CW
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [MW-1:0] coef [ROW_TERMS],
  input  logic signed [CW-1:0] lo_c [AXES],
  input  logic signed [CW-1:0] hi_c [AXES],
  output axis_res_t            res
);

  localparam int PW = MW + CW;        // exact product
  localparam int SW = PW + 3;         // three products, translation, half
  localparam int RW = SW - FRAC_W;    // after rounding shift

  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (CW - 1)));

  // stage A: products for both ends of each input axis
  logic signed [PW-1:0] plo_r [AXES];
  logic signed [PW-1:0] phi_r [AXES];
  logic signed [MW-1:0] ta_r;
  // stage B: per-term extremes
  logic signed [PW-1:0] pmin_r [AXES];
  logic signed [PW-1:0] pmax_r [AXES];
  logic signed [MW-1:0] tb_r;
  // stage C: rounded bounds
  logic signed [RW-1:0] rmin_r;
  logic signed [RW-1:0] rmax_r;

  logic signed [SW-1:0] sum_min;
  logic signed [SW-1:0] sum_max;
  logic signed [SW-1:0] t_sh;
  logic signed [CW-1:0] sat_min;
  logic signed [CW-1:0] sat_max;
  axis_res_t            res_nxt;
  axis_res_t            res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        plo_r[i]  <= PW'(coef[i]) * PW'(lo_c[i]);
        phi_r[i]  <= PW'(coef[i]) * PW'(hi_c[i]);
        pmin_r[i] <= (plo_r[i] < phi_r[i]) ? plo_r[i] : phi_r[i];
        pmax_r[i] <= (plo_r[i] < phi_r[i]) ? phi_r[i] : plo_r[i];
      end
      ta_r   <= coef[TERM_T];
      tb_r   <= ta_r;
      rmin_r <= sum_min[SW-1:FRAC_W];
      rmax_r <= sum_max[SW-1:FRAC_W];
      res_r  <= res_nxt;
    end
  end

  // t in Q16.16 lines up with the product's 32 fraction bits after a 16-bit shift
  assign t_sh = SW'(tb_r) <<< FRAC_W;

  always_comb begin
    sum_min = SW'(pmin_r[TERM_A]) + SW'(pmin_r[TERM_B]) + SW'(pmin_r[TERM_C])
            + t_sh + SW'(Q_HALF);
    sum_max = SW'(pmax_r[TERM_A]) + SW'(pmax_r[TERM_B]) + SW'(pmax_r[TERM_C])
            + t_sh + SW'(Q_HALF);
  end

  always_comb begin
    if (rmin_r < SAT_LO)      sat_min = CW'(SAT_LO);
    else if (rmin_r > SAT_HI) sat_min = CW'(SAT_HI);
    else                      sat_min = CW'(rmin_r);
    if (rmax_r < SAT_LO)      sat_max = CW'(SAT_LO);
    else if (rmax_r > SAT_HI) sat_max = CW'(SAT_HI);
    else                      sat_max = CW'(rmax_r);
    res_nxt.lo  = FIELD_W'(sat_min);
    res_nxt.hi  = FIELD_W'(sat_max);
    // the extreme corners are the only ones that can clip
    res_nxt.ovf = (rmin_r < SAT_LO) || (rmax_r > SAT_HI);
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/aabb_affine_transform_bounds_top.sv =====
// Top level of the transformed 3-D bounding-box block.
// Keeps a 3x4 affine matrix (identity after reset) and maps each box item to
// the axis-aligned bounds of its eight transformed corners, in signed Q16.16.
// Load items (op 0) overwrite one matrix row; row 3 is ignored; loads give no
// result. Box items (op 1) give one result. Each coordinate sum is rounded
// half up once to 16 fraction bits and saturated to COORD_WIDTH bits;
// overflow flags any of the 24 sums clipping. Throughput is one item per
// cycle while no result waits untaken; each result passes five register
// stages: input register, multiply, per-term min/max, four-way add with
// rounding, saturate. The whole pipeline advances on one enable, held off
// only by a waiting, untaken result.
// A load updates the matrix as it leaves the input register, so every box sees
// exactly the loads accepted before it.
module aabb_affine_transform_bounds_top
  import aabb_xf_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  aabb_xf_in_if.sink           in_ch,
  aabb_xf_out_if.source        out_ch
);

  localparam int CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  // matrix entries must also hold the reset value 1.0
  localparam int MW = (CW < FRAC_W + 2) ? FRAC_W + 2 : CW;

  // pipeline control
  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // input register
  logic                 op_r;
  logic [1:0]           row_r;
  logic signed [MW-1:0] cin_r [ROW_TERMS];
  logic signed [CW-1:0] lo_r  [AXES];
  logic signed [CW-1:0] hi_r  [AXES];

  // stored matrix, row-major
  logic signed [MW-1:0] mat_r [AXES][ROW_TERMS];
  logic                 mat_we;

  axis_res_t ax_res [AXES];

  assign en          = !v5_r || out_ch.ready;
  assign in_ch.ready = en;
  assign mat_we      = en && v1_r && (op_r == OP_LOAD) && (row_r != ROW_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r && (op_r == OP_BOX);   // loads stop here
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // input fields narrowed to their low CW bits, sign-extended
  always_ff @(posedge clk) begin
    if (en) begin
      op_r          <= in_ch.op;
      row_r         <= in_ch.row;
      cin_r[TERM_A] <= MW'(signed'(in_ch.coef_a[CW-1:0]));
      cin_r[TERM_B] <= MW'(signed'(in_ch.coef_b[CW-1:0]));
      cin_r[TERM_C] <= MW'(signed'(in_ch.coef_c[CW-1:0]));
      cin_r[TERM_T] <= MW'(signed'(in_ch.coef_t[CW-1:0]));
      lo_r[0]       <= in_ch.min_x[CW-1:0];
      lo_r[1]       <= in_ch.min_y[CW-1:0];
      lo_r[2]       <= in_ch.min_z[CW-1:0];
      hi_r[0]       <= in_ch.max_x[CW-1:0];
      hi_r[1]       <= in_ch.max_y[CW-1:0];
      hi_r[2]       <= in_ch.max_z[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < ROW_TERMS; c++) begin
          mat_r[r][c] <= (r == c) ? MW'(Q_ONE) : '0;
        end
      end
    end else if (mat_we) begin
      for (int r = 0; r < AXES; r++) begin
        if (row_r == 2'(r)) begin
          for (int c = 0; c < ROW_TERMS; c++) begin
            mat_r[r][c] <= cin_r[c];
          end
        end
      end
    end
  end

  // one unit per output axis, each fed by its matrix row
  for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
    aabb_xf_axis #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_axis (
      .clk  (clk),
      .en   (en),
      .coef (mat_r[ax]),
      .lo_c (lo_r),
      .hi_c (hi_r),
      .res  (ax_res[ax])
    );
  end

  assign out_ch.valid     = v5_r;
  assign out_ch.out_min_x = ax_res[0].lo;
  assign out_ch.out_min_y = ax_res[1].lo;
  assign out_ch.out_min_z = ax_res[2].lo;
  assign out_ch.out_max_x = ax_res[0].hi;
  assign out_ch.out_max_y = ax_res[1].hi;
  assign out_ch.out_max_z = ax_res[2].hi;
  assign out_ch.overflow  = ax_res[0].ovf | ax_res[1].ovf | ax_res[2].ovf;

`ifndef SYNTHESIS
  // a load item never reaches the product stage
  a_load_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v1_r && (op_r == OP_LOAD)) |=> !v2_r)
    else $error("load item entered the arithmetic pipeline");

  // a stall freezes every stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r}))
    else $error("pipeline moved during a stall");

  // an accepted box item is held in the input register next cycle
  a_box_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.op == OP_BOX)) |=> (v1_r && (op_r == OP_BOX)))
    else $error("accepted box item lost at input register");

  // bounds are ordered on every axis
  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> ((out_ch.out_min_x <= out_ch.out_max_x) &&
              (out_ch.out_min_y <= out_ch.out_max_y) &&
              (out_ch.out_min_z <= out_ch.out_max_z)))
    else $error("result minimum above maximum");
`endif

endmodule

// ===== tb/sv/tb_aabb_affine_transform_bounds_top.sv =====
// Self-checking testbench for the transformed bounding-box block.
module tb_aabb_affine_transform_bounds_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_xf_pkg::*;

  // Effective value width. The fields are 32 bits, so anything wider acts as 32.
  localparam int VAL_W       = (COORD_WIDTH_DEF < FIELD_W) ? COORD_WIDTH_DEF : FIELD_W;
  localparam int CYCLE_LIMIT = 100000;
  localparam int IDLE_PCT    = 31;
  localparam int TAIL_CYCLES = 20;   // pipeline is 5 deep; leave plenty of slack

  // One item as offered on the input channel.
  typedef struct packed {
    logic               op;
    logic [1:0]         row;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_t;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } xf_item_t;

  // Bounds of one transformed box.
  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic               overflow;
  } bounds_t;

  logic clk;
  logic rst_n;

  aabb_xf_in_if  in_ch ();
  aabb_xf_out_if out_ch ();

  aabb_affine_transform_bounds_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: the 3x4 matrix as the block should hold it, and the
  // bounds still owed by the block, oldest first.
  logic signed [31:0] xf_rows [AXES][ROW_TERMS];
  bounds_t            pending_bounds [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int out_hold       = 0;   // receiver hold-off, counted down by the receiver
  bit tx_quiet       = 1'b0;
  bit rx_quiet       = 1'b0;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Keep the low VAL_W bits of a field, sign-extended.
  function automatic logic signed [31:0] narrow(input logic signed [31:0] v);
    return (v <<< (FIELD_W - VAL_W)) >>> (FIELD_W - VAL_W);
  endfunction

  // a*x + b*y + c*z + t for one axis: exact sum, one half-up rounding,
  // then saturation to VAL_W bits. A 96-bit accumulator holds every case.
  function automatic logic signed [31:0] axis_sum(input int ax,
                                                  input logic signed [31:0] px,
                                                  input logic signed [31:0] py,
                                                  input logic signed [31:0] pz,
                                                  output bit clipped);
    logic signed [95:0] ca, cb, cc, ct, x, y, z, half, acc, lim_hi, lim_lo;
    ca   = xf_rows[ax][TERM_A];
    cb   = xf_rows[ax][TERM_B];
    cc   = xf_rows[ax][TERM_C];
    ct   = xf_rows[ax][TERM_T];
    x    = px;
    y    = py;
    z    = pz;
    half = Q_HALF;
    acc  = ca * x + cb * y + cc * z + (ct <<< FRAC_W) + half;
    acc  = acc >>> FRAC_W;
    lim_hi  = (96'sd1 <<< (VAL_W - 1)) - 96'sd1;
    lim_lo  = -(96'sd1 <<< (VAL_W - 1));
    clipped = 1'b0;
    if (acc > lim_hi) begin
      acc     = lim_hi;
      clipped = 1'b1;
    end else if (acc < lim_lo) begin
      acc     = lim_lo;
      clipped = 1'b1;
    end
    return acc[31:0];
  endfunction

  // Bounds of the eight transformed corners. Swapped corners are taken as
  // given: the bounds simply cover whatever eight points result.
  function automatic bounds_t transform_box(input xf_item_t it);
    logic signed [31:0] lo_in [AXES];
    logic signed [31:0] hi_in [AXES];
    logic signed [31:0] pt    [AXES];
    logic signed [31:0] bmin  [AXES];
    logic signed [31:0] bmax  [AXES];
    logic signed [31:0] v;
    bit                 clipped;
    bit                 any_clip;
    bounds_t            res;
    lo_in[0] = narrow(it.min_x);
    lo_in[1] = narrow(it.min_y);
    lo_in[2] = narrow(it.min_z);
    hi_in[0] = narrow(it.max_x);
    hi_in[1] = narrow(it.max_y);
    hi_in[2] = narrow(it.max_z);
    any_clip = 1'b0;
    for (int corner = 0; corner < 8; corner++) begin
      for (int ax = 0; ax < AXES; ax++)
        pt[ax] = corner[ax] ? hi_in[ax] : lo_in[ax];
      for (int ax = 0; ax < AXES; ax++) begin
        v = axis_sum(ax, pt[0], pt[1], pt[2], clipped);
        any_clip |= clipped;
        if (corner == 0 || v < bmin[ax]) bmin[ax] = v;
        if (corner == 0 || v > bmax[ax]) bmax[ax] = v;
      end
    end
    res.min_x    = bmin[0];
    res.min_y    = bmin[1];
    res.min_z    = bmin[2];
    res.max_x    = bmax[0];
    res.max_y    = bmax[1];
    res.max_z    = bmax[2];
    res.overflow = any_clip;
    return res;
  endfunction

  // Every accepted item moves the predictor: loads update the matrix (row
  // three is dropped), boxes queue their expected bounds. Reset puts the
  // identity back; its 1.0 entries are kept as they are, never narrowed.
  always @(posedge clk) begin
    xf_item_t acc_item;
    if (!rst_n) begin
      for (int r = 0; r < AXES; r++)
        for (int t = 0; t < ROW_TERMS; t++)
          xf_rows[r][t] = (r == t) ? Q_ONE : '0;
    end else if (in_ch.valid && in_ch.ready) begin
      acc_item.op     = in_ch.op;
      acc_item.row    = in_ch.row;
      acc_item.coef_a = in_ch.coef_a;
      acc_item.coef_b = in_ch.coef_b;
      acc_item.coef_c = in_ch.coef_c;
      acc_item.coef_t = in_ch.coef_t;
      acc_item.min_x  = in_ch.min_x;
      acc_item.min_y  = in_ch.min_y;
      acc_item.min_z  = in_ch.min_z;
      acc_item.max_x  = in_ch.max_x;
      acc_item.max_y  = in_ch.max_y;
      acc_item.max_z  = in_ch.max_z;
      if (acc_item.op == OP_LOAD) begin
        if (acc_item.row != ROW_NONE) begin
          xf_rows[acc_item.row][TERM_A] = narrow(acc_item.coef_a);
          xf_rows[acc_item.row][TERM_B] = narrow(acc_item.coef_b);
          xf_rows[acc_item.row][TERM_C] = narrow(acc_item.coef_c);
          xf_rows[acc_item.row][TERM_T] = narrow(acc_item.coef_t);
        end
      end else begin
        pending_bounds.push_back(transform_box(acc_item));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    bounds_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bounds.size() == 0) begin
        $error("result item with no box item outstanding");
        mismatch_count++;
      end else begin
        want = pending_bounds.pop_front();
        check_field("out_min_x", want.min_x, out_ch.out_min_x);
        check_field("out_min_y", want.min_y, out_ch.out_min_y);
        check_field("out_min_z", want.min_z, out_ch.out_min_z);
        check_field("out_max_x", want.max_x, out_ch.out_max_x);
        check_field("out_max_y", want.max_y, out_ch.out_max_y);
        check_field("out_max_z", want.max_z, out_ch.out_max_z);
        check_field("overflow", 32'(want.overflow), 32'(out_ch.overflow));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, a quiet mode and a counted hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_ch.ready <= 1'b0;
        out_hold--;
      end else if (rx_quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item builders and random values
  // ---------------------------------------------------------------------------

  // Unused fields carry noise; the block must ignore them.
  function automatic xf_item_t make_load(input logic [1:0] row,
                                         input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         input logic signed [31:0] c,
                                         input logic signed [31:0] t);
    xf_item_t it;
    it.op     = OP_LOAD;
    it.row    = row;
    it.coef_a = a;
    it.coef_b = b;
    it.coef_c = c;
    it.coef_t = t;
    it.min_x  = $urandom;
    it.min_y  = $urandom;
    it.min_z  = $urandom;
    it.max_x  = $urandom;
    it.max_y  = $urandom;
    it.max_z  = $urandom;
    return it;
  endfunction

  function automatic xf_item_t make_box(input logic signed [31:0] lx,
                                        input logic signed [31:0] ly,
                                        input logic signed [31:0] lz,
                                        input logic signed [31:0] hx,
                                        input logic signed [31:0] hy,
                                        input logic signed [31:0] hz);
    xf_item_t it;
    it.op     = OP_BOX;
    it.row    = 2'($urandom_range(3));
    it.coef_a = $urandom;
    it.coef_b = $urandom;
    it.coef_c = $urandom;
    it.coef_t = $urandom;
    it.min_x  = lx;
    it.min_y  = ly;
    it.min_z  = lz;
    it.max_x  = hx;
    it.max_y  = hy;
    it.max_z  = hz;
    return it;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(6))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sd0;
      3:       return 32'sd1;
      4:       return -32'sd1;
      5:       return Q_ONE;
      default: return -Q_ONE;
    endcase
  endfunction

  // Coordinates: mostly within +/-16.0 so the bounds stay meaningful,
  // with full-range words and extremes mixed in.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return pick_extreme();
      default: return $signed(32'($urandom_range(32'h1F_FFFF))) - 32'sd1048576;
    endcase
  endfunction

  // Coefficients: mostly within +/-4.0.
  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return pick_extreme();
      2:       return 32'sd0;
      default: return $signed(32'($urandom_range(32'h7_FFFF))) - 32'sd262144;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until the block takes it. Idle gaps go in
  // before the item unless the sender is in its quiet stretch.
  task automatic send_item(input xf_item_t it);
    if (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.op     <= it.op;
    in_ch.row    <= it.row;
    in_ch.coef_a <= it.coef_a;
    in_ch.coef_b <= it.coef_b;
    in_ch.coef_c <= it.coef_c;
    in_ch.coef_t <= it.coef_t;
    in_ch.min_x  <= it.min_x;
    in_ch.min_y  <= it.min_y;
    in_ch.min_z  <= it.min_z;
    in_ch.max_x  <= it.max_x;
    in_ch.max_y  <= it.max_y;
    in_ch.max_z  <= it.max_z;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Identity matrix straight after reset: bounds equal the box, even at the
  // extremes of the range, and swapped corners come back ordered.
  task automatic test_identity_reset();
    send_item(make_box(-(Q_ONE + Q_HALF), 2 * Q_ONE, 32'sd0,
                       3 * Q_ONE, 4 * Q_ONE + Q_ONE / 4, Q_HALF));
    send_item(make_box(5 * Q_ONE, 32'sd7, Q_ONE, -5 * Q_ONE, -32'sd7, -Q_ONE));
    send_item(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    wait_for_results();
  endtask

  // Row loads, the ignored row index, half-up rounding and saturation
  // in both directions.
  task automatic test_row_loads();
    // row three writes nothing: identity still in force
    send_item(make_load(ROW_NONE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd12345, -32'sd1));
    send_item(make_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    // x' = 0.5 * x: +half an LSB rounds up, -half an LSB rounds to zero
    send_item(make_load(2'd0, Q_HALF, 32'sd0, 32'sd0, 32'sd0));
    send_item(make_box(-32'sd1, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0));
    // y' = -2y + 10.25, z' = x + y + z - 3
    send_item(make_load(2'd1, 32'sd0, -2 * Q_ONE, 32'sd0, 10 * Q_ONE + Q_ONE / 4));
    send_item(make_load(2'd2, Q_ONE, Q_ONE, Q_ONE, -3 * Q_ONE));
    send_item(make_box(-(Q_ONE + Q_HALF), 32'sd3, Q_ONE / 3,
                       7 * Q_ONE, -9 * Q_ONE, -Q_ONE / 3));
    // largest coefficients against the largest box: both limits clip
    send_item(make_load(2'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh7FFF_FFFF));
    send_item(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_item(make_load(2'd0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh8000_0000));
    send_item(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    // translation alone puts y' exactly at the top limit, without clipping
    send_item(make_load(2'd1, 32'sd0, 32'sd0, 32'sd0, 32'sh7FFF_FFFF));
    send_item(make_box(32'sd0, Q_ONE, 32'sd0, 32'sd0, 2 * Q_ONE, 32'sd0));
    // back to identity
    send_item(make_load(2'd0, Q_ONE, 32'sd0, 32'sd0, 32'sd0));
    send_item(make_load(2'd1, 32'sd0, Q_ONE, 32'sd0, 32'sd0));
    send_item(make_load(2'd2, 32'sd0, 32'sd0, Q_ONE, 32'sd0));
    wait_for_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back to back: the pipeline fills and the input must stall.
  task automatic test_backpressure();
    out_hold = 80;
    tx_quiet = 1'b1;
    for (int i = 0; i < 40; i++)
      send_item(make_box(rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord()));
    tx_quiet = 1'b0;
    wait_for_results();
  endtask

  // Mixed stream: mostly boxes, with matrix reloads (now and then row three)
  // scattered through; a middle stretch runs with no idling on either side.
  task automatic test_random_stream(input int n_items);
    xf_item_t it;
    for (int i = 0; i < n_items; i++) begin
      tx_quiet = (i >= n_items / 3) && (i < n_items / 3 + 150);
      rx_quiet = tx_quiet;
      if ($urandom_range(99) < 22)
        it = make_load(2'($urandom_range(3)), rand_coef(), rand_coef(),
                       rand_coef(), rand_coord());
      else
        it = make_box(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
      send_item(it);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_LOAD;
    in_ch.row    = '0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    in_ch.coef_t = '0;
    in_ch.min_x  = '0;
    in_ch.min_y  = '0;
    in_ch.min_z  = '0;
    in_ch.max_x  = '0;
    in_ch.max_y  = '0;
    in_ch.max_z  = '0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_identity_reset();
    test_row_loads();
    test_backpressure();
    test_random_stream(880);

    // nothing owed; give the pipeline time to show any stray result
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/aabb_xf_pkg.sv
hw/rtl/aabb_xf_if.sv
hw/rtl/aabb_xf_axis.sv
hw/rtl/aabb_affine_transform_bounds_top.sv
tb/sv/tb_aabb_affine_transform_bounds_top.sv
